// ===== design/skd_pkg.sv =====
// Shared types, constants and helpers for the SimCC keypoint decoder.
package skd_pkg;

   localparam int MAX_JOINTS = 26;
   localparam int MAX_BINS   = 1024;

   localparam int BIN_W      = $clog2(MAX_BINS);
   localparam int JCNT_W     = $clog2(MAX_JOINTS + 1);
   localparam int JIDX_W     = 5;
   localparam int LOGIT_W    = 16;
   localparam int ISR_W      = 16;
   localparam int AFF_W      = 32;
   localparam int COORD_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int OFF_SHIFT  = 12;
   localparam int FRAC_SHIFT = 24;

   localparam int P_W     = BIN_W + ISR_W;
   localparam int MUL_B_W = P_W + 1;
   localparam int PROD_W  = AFF_W + MUL_B_W;
   localparam int ACC_W   = PROD_W + 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INV_SPLIT   = 3'd0,
      CSR_AFFINE_XX   = 3'd1,
      CSR_AFFINE_XY   = 3'd2,
      CSR_AFFINE_XOFF = 3'd3,
      CSR_AFFINE_YX   = 3'd4,
      CSR_AFFINE_YY   = 3'd5,
      CSR_AFFINE_YOFF = 3'd6,
      CSR_MIN_SCORE   = 3'd7
   } csr_index_type;

   typedef enum logic [7:0] {
      ST_RUN = 8'b0000_0001,
      ST_PX  = 8'b0000_0010,
      ST_PY  = 8'b0000_0100,
      ST_XA  = 8'b0000_1000,
      ST_XB  = 8'b0001_0000,
      ST_YA  = 8'b0010_0000,
      ST_YB  = 8'b0100_0000,
      ST_FIN = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic                       first_of_frame;
      logic                       axis;
      logic signed [LOGIT_W-1:0]  logit;
      logic                       last_bin;
   } req_type;

   typedef struct packed {
      logic [JIDX_W-1:0]          joint_index;
      logic signed [COORD_W-1:0]  x_coord;
      logic signed [COORD_W-1:0]  y_coord;
      logic signed [LOGIT_W-1:0]  score;
      logic                       valid_res;
   } rsp_type;

   typedef struct packed {
      logic bin_load;
      logic step_px;
      logic step_py;
      logic step_xa;
      logic step_xb;
      logic step_ya;
      logic step_yb;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic emit;
   } stat_type;

   localparam logic signed [ACC_W-1:0] RND_HALF  = ACC_W'(1) << (FRAC_SHIFT - 1);
   localparam logic signed [ACC_W-1:0] COORD_MAX = ACC_W'(2 ** (COORD_W - 1) - 1);
   localparam logic signed [ACC_W-1:0] COORD_MIN = ACC_W'(-(2 ** (COORD_W - 1)));

   // Round half up from Q.28 to Q12.4, then saturate.
   function automatic logic signed [COORD_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] q;
      q = (acc + RND_HALF) >>> FRAC_SHIFT;
      if (q > COORD_MAX) begin
         round_sat = COORD_MAX[COORD_W-1:0];
      end else if (q < COORD_MIN) begin
         round_sat = COORD_MIN[COORD_W-1:0];
      end else begin
         round_sat = q[COORD_W-1:0];
      end
   endfunction

endpackage

// ===== design/skd_req_if.sv =====
// Bin input channel: valid/ready handshake with one bin per transfer.
interface skd_req_if import skd_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== design/skd_rsp_if.sv =====
// Keypoint result channel: valid/ready handshake with one keypoint per transfer.
interface skd_rsp_if import skd_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== design/skd_ctrl.sv =====
// Controller: bin intake, keypoint math sequencing and output handshake.
module skd_ctrl import skd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      out_valid_in = out_valid_ff & ~rsp_ready;
      case (state_ff)
         ST_RUN: begin
            req_ready    = 1'b1;
            cmd.bin_load = req_valid;
            if (req_valid && stat.emit) begin
               state_in = ST_PX;
            end
         end
         ST_PX: begin
            cmd.step_px = 1'b1;
            state_in    = ST_PY;
         end
         ST_PY: begin
            cmd.step_py = 1'b1;
            state_in    = ST_XA;
         end
         ST_XA: begin
            cmd.step_xa = 1'b1;
            state_in    = ST_XB;
         end
         ST_XB: begin
            cmd.step_xb = 1'b1;
            state_in    = ST_YA;
         end
         ST_YA: begin
            cmd.step_ya = 1'b1;
            state_in    = ST_YB;
         end
         ST_YB: begin
            cmd.step_yb = 1'b1;
            state_in    = ST_FIN;
         end
         ST_FIN: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   assign rsp_valid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ===== design/skd_datapath.sv =====
// Datapath: CSRs, running argmax, counters, shared multiplier and result register.
module skd_datapath import skd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  req_type               req_data,
   input  cmd_type               cmd,
   output stat_type              stat,
   output rsp_type               rsp_data
);

   // configuration
   logic [ISR_W-1:0]          isr_ff;
   logic signed [AFF_W-1:0]   xx_ff, xy_ff, xoff_ff, yx_ff, yy_ff, yoff_ff;
   logic signed [LOGIT_W-1:0] min_score_ff;

   // argmax and counters
   logic signed [LOGIT_W-1:0] bx_val_ff, by_val_ff;
   logic [BIN_W-1:0]          bx_idx_ff, by_idx_ff;
   logic [BIN_W-1:0]          bin_ff;
   logic [JCNT_W-1:0]         joint_ff;
   logic [JIDX_W-1:0]         jidx_ff;

   // keypoint math
   logic signed [AFF_W-1:0]   mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod_in, prod_ff;
   logic signed [ACC_W-1:0]   acc_ff, acc_sum;
   logic [P_W-1:0]            px_ff, py_ff;
   logic signed [COORD_W-1:0] x_ff;
   logic signed [LOGIT_W-1:0] score_ff;
   logic                      valid_res_ff;
   logic signed [LOGIT_W:0]   score_sum;
   logic signed [ACC_W-1:0]   xoff_ext, yoff_ext;

   rsp_type rsp_ff;

   logic [BIN_W-1:0]  bin_eff;
   logic [JCNT_W-1:0] joint_eff;
   logic              take_x, take_y;

   assign bin_eff   = req_data.first_of_frame ? '0 : bin_ff;
   assign joint_eff = req_data.first_of_frame ? '0 : joint_ff;
   assign take_x    = (bin_eff == '0) || (req_data.logit > bx_val_ff);
   assign take_y    = (bin_eff == '0) || (req_data.logit > by_val_ff);
   assign stat.emit = req_data.axis && req_data.last_bin &&
                      (joint_eff < JCNT_W'(MAX_JOINTS));

   always_ff @(posedge clock) begin
      if (reset) begin
         isr_ff       <= ISR_W'(2048);
         xx_ff        <= AFF_W'(65536);
         xy_ff        <= '0;
         xoff_ff      <= '0;
         yx_ff        <= '0;
         yy_ff        <= AFF_W'(65536);
         yoff_ff      <= '0;
         min_score_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_INV_SPLIT:   isr_ff       <= csr_wdata[ISR_W-1:0];
            CSR_AFFINE_XX:   xx_ff        <= csr_wdata;
            CSR_AFFINE_XY:   xy_ff        <= csr_wdata;
            CSR_AFFINE_XOFF: xoff_ff      <= csr_wdata;
            CSR_AFFINE_YX:   yx_ff        <= csr_wdata;
            CSR_AFFINE_YY:   yy_ff        <= csr_wdata;
            CSR_AFFINE_YOFF: yoff_ff      <= csr_wdata;
            CSR_MIN_SCORE:   min_score_ff <= csr_wdata[LOGIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bx_val_ff <= '0;
         by_val_ff <= '0;
         bx_idx_ff <= '0;
         by_idx_ff <= '0;
         bin_ff    <= '0;
         joint_ff  <= '0;
      end else if (cmd.bin_load) begin
         if (!req_data.axis && take_x) begin
            bx_val_ff <= req_data.logit;
            bx_idx_ff <= bin_eff;
         end
         if (req_data.axis && take_y) begin
            by_val_ff <= req_data.logit;
            by_idx_ff <= bin_eff;
         end
         if (req_data.last_bin) begin
            bin_ff <= '0;
         end else if (bin_eff < BIN_W'(MAX_BINS - 1)) begin
            bin_ff <= bin_eff + 1'b1;
         end else begin
            bin_ff <= bin_eff;
         end
         if (stat.emit) begin
            joint_ff <= joint_eff + 1'b1;
         end else begin
            joint_ff <= joint_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.bin_load && stat.emit) begin
         jidx_ff <= JIDX_W'(joint_eff);
      end
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = signed'(AFF_W'(isr_ff));
      mul_b = signed'(MUL_B_W'(bx_idx_ff));
      if (cmd.step_py) begin
         mul_b = signed'(MUL_B_W'(by_idx_ff));
      end else if (cmd.step_xa) begin
         mul_a = xx_ff;
         mul_b = signed'(MUL_B_W'(px_ff));
      end else if (cmd.step_xb) begin
         mul_a = xy_ff;
         mul_b = signed'(MUL_B_W'(py_ff));
      end else if (cmd.step_ya) begin
         mul_a = yx_ff;
         mul_b = signed'(MUL_B_W'(px_ff));
      end else if (cmd.step_yb) begin
         mul_a = yy_ff;
         mul_b = signed'(MUL_B_W'(py_ff));
      end
   end

   assign prod_in   = mul_a * mul_b;
   assign acc_sum   = acc_ff + ACC_W'(prod_ff);
   assign xoff_ext  = ACC_W'(xoff_ff) <<< OFF_SHIFT;
   assign yoff_ext  = ACC_W'(yoff_ff) <<< OFF_SHIFT;
   assign score_sum = (LOGIT_W + 1)'(bx_val_ff) + (LOGIT_W + 1)'(by_val_ff);

   always_ff @(posedge clock) begin
      if (cmd.step_px || cmd.step_py || cmd.step_xa || cmd.step_xb ||
          cmd.step_ya || cmd.step_yb) begin
         prod_ff <= prod_in;
      end
      if (cmd.step_px) begin
         score_ff     <= score_sum[LOGIT_W:1];
         valid_res_ff <= signed'(score_sum[LOGIT_W:1]) >= min_score_ff;
      end
      if (cmd.step_py) begin
         px_ff <= prod_ff[P_W-1:0];
      end
      if (cmd.step_xa) begin
         py_ff  <= prod_ff[P_W-1:0];
         acc_ff <= xoff_ext;
      end
      if (cmd.step_xb || cmd.step_yb) begin
         acc_ff <= acc_sum;
      end
      if (cmd.step_ya) begin
         x_ff   <= round_sat(acc_sum);
         acc_ff <= yoff_ext;
      end
      if (cmd.out_load) begin
         rsp_ff.joint_index <= jidx_ff;
         rsp_ff.x_coord     <= x_ff;
         rsp_ff.y_coord     <= round_sat(acc_sum);
         rsp_ff.score       <= score_ff;
         rsp_ff.valid_res   <= valid_res_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== design/simcc_keypoint_decoder_top.sv =====
// Top level of the SimCC keypoint decoder.
//
//   channel  dir  transfer unit                 handshake
//   req_ch   in   one logit bin                 valid/ready
//   rsp_ch   out  one decoded keypoint          valid/ready
//   csr_*    in   one register write            write enable only
//
// A bin transfers every cycle in which req_ch.ready is high. A Y last bin
// that yields a keypoint holds ready low while the shared multiplier forms
// the scaled indices and the two affine rows, and longer if the previous
// keypoint still waits in the output register. Reset is synchronous and
// restores the register defaults and clears the argmax and joint state.
module simcc_keypoint_decoder_top import skd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   skd_req_if.sink               req_ch,
   skd_rsp_if.source             rsp_ch,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   skd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   skd_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_data     (req_ch.data),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_data     (rsp_ch.data)
   );

endmodule

// ===== design/skd_checker.sv =====
// Port-level assertions for the SimCC keypoint decoder, bound to the top level.
module skd_checker import skd_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("rsp_valid dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_data))
      else $error("rsp payload changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending right after reset");

   a_new_after_math: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (!$past(rsp_valid) || $past(rsp_ready))) |-> !$past(req_ready))
      else $error("keypoint appeared without a math sequence");

endmodule

bind simcc_keypoint_decoder_top skd_checker u_skd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  (rsp_ch.data)
);
